/* src/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the software timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int MAX_TIMERS = 8;
    localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_CREATE  = 2'd1,
        FUNC_RESTART = 2'd2,
        FUNC_DELETE  = 2'd3
    } func_t;

    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef struct packed {
        func_t       func;
        logic [63:0] now_ms;
        logic [31:0] interval_ms;
        logic        repeat_req;
        logic [7:0]  timer_id;
    } req_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] result_id;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  id;
        logic        rpt;
        logic [31:0] interval;
        logic [63:0] expiry;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPLY,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

/* src/software_timer_table_unit.sv */
// ----------------------------------------------------------------------------
// software_timer_table_unit
// Ordered table of periodic and one-shot timers held in one memory.
// ----------------------------------------------------------------------------
// A create request returns its reply through the output register. Tick,
// restart and delete walk the table through the single read port of the entry
// memory, one entry per cycle unless the output side stalls the walk, and a
// tick then sends its final expiry. A walk writes each kept entry back to the
// next free slot, so removal closes up the table in the same pass. A new
// request is taken once the last result is in the output register, even while
// that result waits on the output.
module software_timer_table_unit
    import stt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    entry_t mem [MAX_TIMERS];
    entry_t rdata_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_raddr;
    entry_t            mem_wdata;

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [7:0]        next_id_reg, next_id_next;
    logic [IDX_W-1:0]  rd_reg, rd_next;
    logic [IDX_W-1:0]  wr_reg, wr_next;
    logic              found_reg, found_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [7:0]        pend_id_reg, pend_id_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    logic   out_free;
    logic   out_load;
    rsp_t   out_data;
    logic   accept;
    logic   hit;
    logic   expired;
    logic   keep;
    logic   emit;
    logic   hold;
    logic   at_end;
    entry_t upd;
    logic [7:0] id_inc;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        used_next       = used_reg;
        next_id_next    = next_id_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        mem_we          = 1'b0;
        mem_waddr       = wr_reg;
        mem_raddr       = '0;
        mem_wdata       = rdata_reg;
        out_load        = 1'b0;
        out_data        = out_reg;
        hit             = 1'b0;
        expired         = 1'b0;
        keep            = 1'b1;
        emit            = 1'b0;
        hold            = 1'b0;
        at_end          = 1'b0;
        upd             = rdata_reg;
        id_inc          = next_id_reg + 8'd1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req;
                    rd_next    = '0;
                    wr_next    = '0;
                    found_next = 1'b0;
                    if (req.func == FUNC_CREATE)
                    begin
                        state_next   = ST_REPLY;
                        pend_id_next = 8'd0;
                        if (used_reg < CNT_W'(MAX_TIMERS))
                        begin
                            mem_we           = 1'b1;
                            mem_waddr        = used_reg[IDX_W-1:0];
                            mem_wdata.id       = next_id_reg;
                            mem_wdata.rpt      = req.repeat_req;
                            mem_wdata.interval = req.interval_ms;
                            mem_wdata.expiry   = req.now_ms + 64'(req.interval_ms);
                            used_next        = used_reg + CNT_W'(1);
                            pend_id_next     = next_id_reg;
                            next_id_next     = (id_inc == 8'd0) ? 8'd1 : id_inc;
                        end
                    end
                    else if (used_reg != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_REPLY:
            begin
                // pend_id_reg carries the create reply id here
                if (out_free)
                begin
                    out_load           = 1'b1;
                    out_data.kind      = KIND_REPLY;
                    out_data.result_id = pend_id_reg;
                    out_data.last      = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                hit     = (rdata_reg.id == req_reg.timer_id) && !found_reg;
                expired = (req_reg.now_ms >= rdata_reg.expiry);
                at_end  = (CNT_W'(rd_reg) == used_reg - CNT_W'(1));
                case (req_reg.func)
                    FUNC_TICK:
                    begin
                        if (expired)
                        begin
                            emit       = 1'b1;
                            keep       = rdata_reg.rpt;
                            upd.expiry = rdata_reg.expiry + 64'(rdata_reg.interval);
                        end
                    end
                    FUNC_RESTART:
                    begin
                        if (hit)
                        begin
                            upd.expiry = req_reg.now_ms + 64'(rdata_reg.interval);
                            found_next = 1'b1;
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (hit)
                        begin
                            keep       = 1'b0;
                            found_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        keep = 1'b1;
                    end
                endcase

                hold = emit && pend_valid_reg && !out_free;
                if (hold)
                begin
                    mem_raddr  = rd_reg;
                    found_next = found_reg;
                end
                else
                begin
                    if (keep)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = wr_reg;
                        mem_wdata = upd;
                        wr_next   = wr_reg + IDX_W'(1);
                    end
                    if (emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load           = 1'b1;
                            out_data.kind      = KIND_EXPIRY;
                            out_data.result_id = pend_id_reg;
                            out_data.last      = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = rdata_reg.id;
                    end
                    if (at_end)
                    begin
                        used_next  = CNT_W'(wr_reg) + CNT_W'(keep);
                        state_next = pend_valid_next ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        rd_next   = rd_reg + IDX_W'(1);
                        mem_raddr = rd_reg + IDX_W'(1);
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    out_data.kind      = KIND_EXPIRY;
                    out_data.result_id = pend_id_reg;
                    out_data.last      = 1'b1;
                    pend_valid_next    = 1'b0;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = out_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            next_id_reg    <= 8'd1;
            rd_reg         <= '0;
            wr_reg         <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            next_id_reg    <= next_id_next;
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        pend_id_reg <= pend_id_next;
        out_reg     <= out_next;
    end

endmodule

/* tb/software_timer_table_unit_tb.sv */
// ----------------------------------------------------------------------------
// software_timer_table_unit_tb
// Self-checking bench for the software timer table unit. A scoreboard keeps
// its own copy of the timer table and predicts the create replies and tick
// expiry events of every accepted request. Every result the block returns is
// compared with the oldest prediction. The stimulus starts with a directed
// list, then full-table create bursts walk the id counter through its wrap,
// then a random mix of creates, ticks, restarts and deletes runs under a
// rising time stamp. Both sides insert random idle cycles, and one long
// output hold lets the block back up and stall its input.
// ----------------------------------------------------------------------------
import stt_pkg::*;

class timer_table_scoreboard;
    entry_t     slots [MAX_TIMERS];
    int         used;
    logic [7:0] next_id;
    bit         id_wrapped;
    rsp_t       pending_q [$];
    int         errors;
    int         requests;
    int         replies;
    int         full_replies;
    int         expiries;
    int         checked;

    function new();
        used         = 0;
        next_id      = 8'd1;
        id_wrapped   = 1'b0;
        errors       = 0;
        requests     = 0;
        replies      = 0;
        full_replies = 0;
        expiries     = 0;
        checked      = 0;
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 100)
            $display("mismatch: %s", msg);
    endtask

    function void remove_slot(int pos);
        for (int k = pos + 1; k < used; k++)
            slots[k - 1] = slots[k];
        used--;
    endfunction

    function void note_request(req_t r);
        rsp_t e;
        int   k;
        int   hit;
        int   n_before;
        requests++;
        case (r.func)
            FUNC_CREATE:
            begin
                e.kind      = KIND_REPLY;
                e.result_id = 8'd0;
                e.last      = 1'b1;
                if (used < MAX_TIMERS)
                begin
                    slots[used].id       = next_id;
                    slots[used].rpt      = r.repeat_req;
                    slots[used].interval = r.interval_ms;
                    slots[used].expiry   = r.now_ms + {32'd0, r.interval_ms};
                    used++;
                    e.result_id = next_id;
                    next_id     = next_id + 8'd1;
                    if (next_id == 8'd0)
                    begin
                        next_id    = 8'd1;
                        id_wrapped = 1'b1;
                    end
                end
                else
                    full_replies++;
                replies++;
                pending_q.push_back(e);
            end
            FUNC_TICK:
            begin
                n_before = pending_q.size();
                k = 0;
                while (k < used)
                begin
                    if (r.now_ms >= slots[k].expiry)
                    begin
                        e.kind      = KIND_EXPIRY;
                        e.result_id = slots[k].id;
                        e.last      = 1'b0;
                        pending_q.push_back(e);
                        expiries++;
                        if (slots[k].rpt)
                        begin
                            slots[k].expiry = slots[k].expiry + {32'd0, slots[k].interval};
                            k++;
                        end
                        else
                            remove_slot(k);
                    end
                    else
                        k++;
                end
                if (pending_q.size() > n_before)
                    pending_q[pending_q.size() - 1].last = 1'b1;
            end
            default:
            begin
                hit = -1;
                for (int j = 0; j < used; j++)
                    if (hit < 0 && slots[j].id == r.timer_id)
                        hit = j;
                if (hit >= 0)
                begin
                    if (r.func == FUNC_RESTART)
                        slots[hit].expiry = r.now_ms + {32'd0, slots[hit].interval};
                    else
                        remove_slot(hit);
                end
            end
        endcase
    endfunction

    task check_response(rsp_t r);
        rsp_t want;
        checked++;
        if (pending_q.size() == 0)
        begin
            report($sformatf("result %0d with none pending: kind %0d id %0d last %0d",
                             checked, r.kind, r.result_id, r.last));
            return;
        end
        want = pending_q.pop_front();
        if (r.kind !== want.kind)
            report($sformatf("result %0d kind %0d, want %0d", checked, r.kind, want.kind));
        if (r.result_id !== want.result_id)
            report($sformatf("result %0d id %0d, want %0d",
                             checked, r.result_id, want.result_id));
        if (r.last !== want.last)
            report($sformatf("result %0d last %0d, want %0d", checked, r.last, want.last));
    endtask
endclass

module software_timer_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    logic        output_hold;
    logic [63:0] now_stamp;
    bit          fast_phase;
    int          sent;

    timer_table_scoreboard sb;

    software_timer_table_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic req_t make_req(func_t f, logic [63:0] t, logic [31:0] iv,
                                      logic rp, logic [7:0] id);
        req_t r;
        r.func        = f;
        r.now_ms      = t;
        r.interval_ms = iv;
        r.repeat_req  = rp;
        r.timer_id    = id;
        return r;
    endfunction

    function automatic req_t random_request();
        req_t        r;
        int unsigned sel;
        int unsigned step;
        step = $urandom_range(0, 25);
        if (now_stamp > ~64'd0 - step)
            now_stamp = ~64'd0;
        else
            now_stamp = now_stamp + step;
        sel = $urandom_range(0, 99);
        if (sel < 58)
            r.func = FUNC_CREATE;
        else if (sel < 80)
            r.func = FUNC_TICK;
        else if (sel < 88)
            r.func = FUNC_RESTART;
        else
            r.func = FUNC_DELETE;
        r.now_ms = now_stamp;
        case ($urandom_range(0, 19))
            0:       r.interval_ms = '0;
            1:       r.interval_ms = $urandom;
            2:       r.interval_ms = '1;
            default: r.interval_ms = $urandom_range(1, 60);
        endcase
        r.repeat_req = ($urandom_range(0, 99) < 12);
        r.timer_id   = $urandom_range(0, 255);
        if ((r.func == FUNC_RESTART || r.func == FUNC_DELETE) && sb.used > 0
            && $urandom_range(0, 4) != 0)
            r.timer_id = sb.slots[$urandom_range(0, sb.used - 1)].id;
        return r;
    endfunction

    // valid stays high across back-to-back requests
    task automatic issue(input req_t r);
        int gap;
        gap = fast_phase ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(r);
        sent++;
    endtask

    initial
    begin
        int n;
        sb         = new();
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        sent       = 0;
        fast_phase = 1'b0;
        now_stamp  = 64'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(make_req(FUNC_CREATE, 64'd0, 32'd0, 1'b1, 8'd0));
        issue(make_req(FUNC_CREATE, 64'd0, 32'd10, 1'b0, 8'd0));
        issue(make_req(FUNC_CREATE, 64'd1, 32'd9, 1'b0, 8'd0));
        issue(make_req(FUNC_CREATE, 64'd2, 32'hFFFF_FFFF, 1'b0, 8'hFF));
        issue(make_req(FUNC_TICK, 64'd5, 32'd0, 1'b0, 8'd0));
        issue(make_req(FUNC_TICK, 64'd5, 32'd0, 1'b0, 8'd0));
        // adjacent one-shots expire together
        issue(make_req(FUNC_TICK, 64'd10, 32'd0, 1'b0, 8'd0));
        issue(make_req(FUNC_DELETE, 64'd10, 32'd0, 1'b0, 8'd1));
        issue(make_req(FUNC_TICK, 64'd11, 32'd0, 1'b0, 8'd0));
        for (int i = 0; i < 7; i++)
            issue(make_req(FUNC_CREATE, 64'd12, 32'(i * 3 + 1), i[0], 8'd0));
        issue(make_req(FUNC_CREATE, 64'd12, 32'd5, 1'b1, 8'd0));
        issue(make_req(FUNC_RESTART, 64'd20, 32'd0, 1'b0, 8'd7));
        issue(make_req(FUNC_RESTART, 64'd20, 32'd0, 1'b0, 8'hFF));
        issue(make_req(FUNC_DELETE, 64'd20, 32'd0, 1'b0, 8'd8));
        issue(make_req(FUNC_DELETE, 64'd20, 32'd0, 1'b0, 8'd0));
        issue(make_req(FUNC_TICK, 64'd40, 32'd0, 1'b0, 8'd0));
        issue(make_req(FUNC_CREATE, 64'd40, 32'd3, 1'b0, 8'd0));

        now_stamp = 64'd40;
        while (sb.used > 0)
            issue(make_req(FUNC_DELETE, now_stamp, 32'd0, 1'b0, sb.slots[0].id));

        // fill the table with due one-shots, then clear it with a full tick,
        // until the id counter has wrapped
        while (!sb.id_wrapped)
        begin
            while (sb.used < MAX_TIMERS)
                issue(make_req(FUNC_CREATE, now_stamp, 32'd0, 1'b0, 8'd0));
            issue(make_req(FUNC_TICK, now_stamp, 32'd0, 1'b0, 8'd0));
        end

        n = 0;
        while (n < 130)
        begin
            if (n == 40)
                now_stamp = {2'b01, 30'($urandom), 32'($urandom)};
            if (n == 90)
                now_stamp = 64'hFFFF_FFFF_FFFF_F000;
            fast_phase = ((n / 50) % 3 == 0);
            issue(random_request());
            n++;
        end
        req_valid <= 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d requests: %0d create replies (%0d on a full table), %0d expiries.",
                 sb.requests, sb.replies, sb.full_replies, sb.expiries);
        $display("Final time stamp %h, id counter wrap %s.",
                 now_stamp, sb.id_wrapped ? "seen" : "not seen");
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int rx_wait;
        int rx_count;
        rx_wait   = 0;
        rx_count  = 0;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                sb.check_response(rsp);
                rx_count++;
                rx_wait = ((rx_count / 40) % 3 == 0) ? 0 : $urandom_range(0, 18);
            end
            else if (rsp_valid && rx_wait > 0)
                rx_wait--;
            rsp_stall <= output_hold || (rx_wait > 0);
        end
    end

    // long output hold so the block backs up and stalls its input
    initial
    begin
        output_hold = 1'b0;
        wait (sent >= 150);
        output_hold <= 1'b1;
        repeat (300) @(posedge clk);
        output_hold <= 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results still pending", sb.pending_q.size());
        $display("*** FAILED ***");
        $finish;
    end
endmodule
